// ===== src/hce_pkg.sv =====
// Shared types, codes and helper functions for the chunked transfer encoder.
`default_nettype none

package hce_pkg;

  // Output byte source select
  localparam logic [1:0] SEL_HEX  = 2'd0;
  localparam logic [1:0] SEL_CR   = 2'd1;
  localparam logic [1:0] SEL_LF   = 2'd2;
  localparam logic [1:0] SEL_DATA = 2'd3;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  // Commands from controller to datapath
  typedef struct packed {
    logic       store;    // write the accepted body byte, bump held count
    logic       prep;     // set up digit counter and read index
    logic       load;     // load output register
    logic [1:0] sel;      // output byte source
    logic       last;     // final byte of the chunk
    logic       dig_dec;  // step to next hex digit
    logic       idx_inc;  // step to next payload byte
    logic       clr;      // chunk done, empty the store
  } hce_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full_next;  // this store fills the chunk
    logic empty;      // no bytes held
    logic dig_zero;   // on the lowest hex digit
    logic data_end;   // on the last payload byte
    logic out_free;   // output register can take a byte
  } hce_status_t;

  // Number of hex digits of a value, no leading zeros (at least one)
  function automatic int hex_digits(input int v);
    int d;
    int x;
    d = 1;
    x = v;
    for (int i = 0; i < 8; i++) begin
      if (x >= 16) begin
        x = x >> 4;
        d = d + 1;
      end
    end
    return d;
  endfunction

  // Lower-case ASCII hex character
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/hce_dp.sv =====
// Datapath: chunk store memory, held count, hex digit select and output register.
`default_nettype none

module hce_dp #(
  parameter int MAX_PAYLOAD = 57
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hce_pkg::hce_cmd_t   cmd,
  output hce_pkg::hce_status_t     status,
  input  wire logic [7:0]          s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [7:0]               m_tdata,
  output logic                     m_tlast
);
  import hce_pkg::*;

  localparam int CW  = $clog2(MAX_PAYLOAD + 1);
  localparam int AW  = $clog2(MAX_PAYLOAD);
  localparam int ND  = (CW + 3) / 4;
  localparam int DCW = (ND > 1) ? $clog2(ND) : 1;

  logic [7:0]      mem [MAX_PAYLOAD];
  logic [7:0]      rd_data;
  logic [CW-1:0]   held_count;
  logic [AW-1:0]   idx;
  logic [AW-1:0]   idx_next;
  logic [DCW-1:0]  dig;
  logic [DCW-1:0]  dig_top;
  logic [ND*4-1:0] count_pad;
  logic [3:0]      nib;
  logic [7:0]      byte_mux;

  // Store write and registered read; read address follows the next index
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[held_count[AW-1:0]] <= s_tdata;
    end
    rd_data <= mem[idx_next];
  end

  always_comb begin
    if (cmd.prep) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + AW'(1);
    end else begin
      idx_next = idx;
    end
  end

  // Held byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.clr) begin
      held_count <= '0;
    end else if (cmd.store) begin
      held_count <= held_count + CW'(1);
    end
  end

  // Highest nonzero nibble of the count
  assign count_pad = (ND*4)'(held_count);
  always_comb begin
    dig_top = '0;
    for (int i = 1; i < ND; i++) begin
      if (count_pad[i*4 +: 4] != 4'd0) begin
        dig_top = DCW'(i);
      end
    end
  end

  // Digit counter and payload index
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dig <= dig_top;
    end else if (cmd.dig_dec) begin
      dig <= dig - DCW'(1);
    end
    idx <= idx_next;
  end

  assign nib = count_pad[dig*4 +: 4];

  // Output byte source
  always_comb begin
    case (cmd.sel)
      SEL_HEX:  byte_mux = hex_char(nib);
      SEL_CR:   byte_mux = CHAR_CR;
      SEL_LF:   byte_mux = CHAR_LF;
      default:  byte_mux = rd_data;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= byte_mux;
      m_tlast <= cmd.last;
    end
  end

  // Status back to the controller
  assign status.full_next = (held_count + CW'(1)) == CW'(MAX_PAYLOAD);
  assign status.empty     = (held_count == '0);
  assign status.dig_zero  = (dig == '0);
  assign status.data_end  = (CW'(idx) + CW'(1)) == held_count;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire

// ===== src/hce_ctrl.sv =====
// Controller: accepts items and sequences the chunk header, payload and trailer.
`default_nettype none

module hce_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic                 s_tuser,
  input  wire hce_pkg::hce_status_t status,
  output hce_pkg::hce_cmd_t         cmd
);
  import hce_pkg::*;

  localparam logic [3:0] S_ACCEPT = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_HEX    = 4'd2;
  localparam logic [3:0] S_CR1    = 4'd3;
  localparam logic [3:0] S_LF1    = 4'd4;
  localparam logic [3:0] S_DATA   = 4'd5;
  localparam logic [3:0] S_CR2    = 4'd6;
  localparam logic [3:0] S_LF2    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       term;
  logic       term_next;
  logic       accept;

  assign s_tready = (state == S_ACCEPT) || (state == S_DONE);
  assign accept   = s_tvalid && s_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    term_next  = term;
    cmd        = '0;
    cmd.sel    = SEL_HEX;
    unique case (state)
      S_ACCEPT: begin
        if (accept) begin
          if (!s_tuser) begin
            cmd.store = 1'b1;
            if (status.full_next) begin
              state_next = S_PREP;
            end
          end else begin
            term_next  = status.empty;
            state_next = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_HEX;
      end
      S_HEX: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = SEL_HEX;
          if (status.dig_zero) begin
            state_next = S_CR1;
          end else begin
            cmd.dig_dec = 1'b1;
          end
        end
      end
      S_CR1: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = SEL_CR;
          state_next = S_LF1;
        end
      end
      S_LF1: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = SEL_LF;
          state_next = status.empty ? S_CR2 : S_DATA;
        end
      end
      S_DATA: begin
        if (status.out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = SEL_DATA;
          cmd.idx_inc = 1'b1;
          if (status.data_end) begin
            state_next = S_CR2;
          end
        end
      end
      S_CR2: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = SEL_CR;
          state_next = S_LF2;
        end
      end
      S_LF2: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = SEL_LF;
          cmd.last   = 1'b1;
          cmd.clr    = 1'b1;
          state_next = term ? S_DONE : S_ACCEPT;
        end
      end
      S_DONE: begin
        state_next = S_DONE;
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
      term  <= 1'b0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

`ifndef SYNTH
  // Terminal chunk sent: stream stays closed
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> state == S_DONE)
    else $error("done state left");

  // Output register is never overwritten while a byte waits
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> status.out_free)
    else $error("output loaded while busy");

  // Payload bytes are read only when bytes are held
  assert property (@(posedge clk) disable iff (rst)
    state == S_DATA |-> !status.empty)
    else $error("payload read from empty store");

  // A terminal chunk never carries payload
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LF1 && term && cmd.load) |=> state == S_CR2)
    else $error("terminal chunk with payload");
`endif

endmodule

`default_nettype wire

// ===== src/http_chunked_encoder.sv =====
// Top level of the HTTP/1.1 chunked transfer encoder.
//
//   channel   dir  tdata             tuser / tlast
//   s_*       in   body_byte [7:0]   tuser: func (1 = flush)
//   m_*       out  out_byte  [7:0]   tlast: chunk_last
//
// A body byte that does not fill the store leaves the input ready for the next.
// A chunk of n bytes: a setup state, then (hex digits of n) + n + 4 bytes out
// through the single output register, one byte per cycle while m_tready is high.
// Output stalls hold the sequencer; no input is taken while a chunk goes out.
// Reset empties the store and reopens the stream; after the terminal chunk
// every input transaction is taken and dropped.
`default_nettype none

module http_chunked_encoder #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] body_byte
  input  wire logic       s_tuser,   // [0] func
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast
);
  import hce_pkg::*;

  localparam int MAX_PAYLOAD = BUFFER_BYTES - (hex_digits(BUFFER_BYTES) + 3) - 2;

  hce_cmd_t    cmd;
  hce_status_t status;

  hce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  hce_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/http_chunked_encoder_tb.sv =====
// Self-checking testbench for the HTTP/1.1 chunked transfer encoder.
module http_chunked_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFER_BYTES = 64;
  localparam int DRAIN_CYCLES = 80;
  localparam int DATA_TARGET  = 90;

  // func codes carried on s_tuser
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic [7:0] ASCII_CR   = 8'h0d;
  localparam logic [7:0] ASCII_LF   = 8'h0a;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h61;

  // One expected byte of the chunked stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_last;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] body_byte
  logic       s_tuser = 1'b0;    // [0] func
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // chunk_last

  // Encoder state as predicted
  logic [7:0] store_bytes [0:BUFFER_BYTES-1];
  int         held_bytes;
  bit         stream_closed;
  int         chunk_limit;

  out_beat_t  chunk_bytes_q [$];
  out_beat_t  want_beat;
  int         fail_count = 0;
  int         data_sent = 0;
  int         tx_max_gap = 6;
  int         rx_max_stall = 6;
  int         rx_stall = 0;

  http_chunked_encoder #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Hex digit count, no leading zeros
  function automatic int digit_count(input int v);
    int d;
    d = 1;
    while (v >= 16) begin
      v = v >> 4;
      d++;
    end
    return d;
  endfunction

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ASCII_ZERO + 8'(nib);
    end else begin
      c = ASCII_A + 8'(nib) - 8'd10;
    end
    return c;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic last_flag);
    out_beat_t beat;
    beat.out_byte   = b;
    beat.chunk_last = last_flag;
    chunk_bytes_q.push_back(beat);
  endfunction

  // Queue header, payload and trailer of the held bytes, then empty the store
  function automatic void queue_chunk();
    int nd;
    nd = digit_count(held_bytes);
    for (int i = nd - 1; i >= 0; i--) begin
      push_beat(ascii_hex(4'((held_bytes >> (4 * i)) & 15)), 1'b0);
    end
    push_beat(ASCII_CR, 1'b0);
    push_beat(ASCII_LF, 1'b0);
    for (int i = 0; i < held_bytes; i++) begin
      push_beat(store_bytes[i], 1'b0);
    end
    push_beat(ASCII_CR, 1'b0);
    push_beat(ASCII_LF, 1'b1);
    held_bytes = 0;
  endfunction

  // Expected stream bytes caused by one accepted transaction
  function automatic void encode_item(input logic func, input logic [7:0] b);
    if (stream_closed) begin
      return;
    end
    if (func == FUNC_DATA) begin
      store_bytes[held_bytes] = b;
      held_bytes++;
      if (held_bytes >= chunk_limit) begin
        queue_chunk();
      end
    end else if (held_bytes > 0) begin
      queue_chunk();
    end else begin
      push_beat(ASCII_ZERO, 1'b0);
      push_beat(ASCII_CR, 1'b0);
      push_beat(ASCII_LF, 1'b0);
      push_beat(ASCII_CR, 1'b0);
      push_beat(ASCII_LF, 1'b1);
      stream_closed = 1'b1;
    end
  endfunction

  // Send one transaction; called and returns at a falling edge
  task automatic send_item(input logic func, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    encode_item(func, b);
    if (func == FUNC_DATA && !stream_closed) begin
      data_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_flush();
    send_item(FUNC_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  // Extremes of the byte, short chunks, single-byte chunk
  task automatic test_short_chunks();
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, 8'hff);
    send_item(FUNC_DATA, 8'h80);
    send_item(FUNC_DATA, 8'h01);
    send_flush();
    send_item(FUNC_DATA, 8'h55);
    send_item(FUNC_DATA, 8'haa);
    send_flush();
    send_item(FUNC_DATA, 8'h7f);
    send_flush();
  endtask

  // Store fills and emits without a flush, then a short remainder
  task automatic test_full_chunk();
    while (held_bytes < chunk_limit - 1) begin
      send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
    end
    send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
    send_item(FUNC_DATA, 8'h3c);
    send_flush();
  endtask

  // Random runs of data bytes closed by flushes, with bursts of no idling
  task automatic test_random_runs();
    int run_len;
    int pick;
    while (data_sent < DATA_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        run_len = $urandom_range(1, 20);
      end else if (pick < 9) begin
        run_len = $urandom_range(9, 17);
      end else begin
        run_len = $urandom_range(50, 64);
      end
      if (run_len > DATA_TARGET - data_sent) begin
        run_len = DATA_TARGET - data_sent;
      end
      if ($urandom_range(0, 3) == 0) begin
        tx_max_gap   = 0;
        rx_max_stall = 0;
      end else begin
        tx_max_gap   = 6;
        rx_max_stall = 6;
      end
      repeat (run_len) send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
      // an empty-store flush would end the stream early
      if (held_bytes > 0) begin
        send_flush();
      end
    end
    tx_max_gap   = 6;
    rx_max_stall = 6;
  endtask

  // Terminal chunk on an empty store
  task automatic test_terminal_chunk();
    if (held_bytes > 0) begin
      send_flush();
    end
    send_flush();
  endtask

  // After the terminal chunk every transaction is dropped
  task automatic test_after_close();
    repeat (3) send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
    send_flush();
    send_item(FUNC_DATA, 8'hff);
    send_flush();
  endtask

  // Receiver backpressure: a fresh stall count after every output transaction
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Output checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (chunk_bytes_q.size() == 0) begin
        $display("%0t: out_byte expected none actual %02h last %0b", $time,
                 m_tdata, m_tlast);
        fail_count++;
      end else begin
        want_beat = chunk_bytes_q.pop_front();
        if (m_tdata !== want_beat.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   want_beat.out_byte, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want_beat.chunk_last) begin
          $display("%0t: chunk_last expected %0b actual %0b", $time,
                   want_beat.chunk_last, m_tlast);
          fail_count++;
        end
      end
      rx_stall = $urandom_range(0, rx_max_stall);
    end
  end

  // Main sequence
  initial begin
    held_bytes    = 0;
    stream_closed = 1'b0;
    chunk_limit   = BUFFER_BYTES - (digit_count(BUFFER_BYTES) + 3) - 2;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_short_chunks();
    test_full_chunk();
    test_random_runs();
    test_terminal_chunk();
    test_after_close();
    s_tvalid <= 1'b0;
    while (chunk_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chunk_bytes_q.size() != 0) begin
      $display("%0t: %0d output bytes never arrived", $time, chunk_bytes_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("http_chunked_encoder test passed");
    end else begin
      $display("http_chunked_encoder test failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("http_chunked_encoder test failed");
    $finish;
  end

endmodule
